// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a stalled signal keeps its value in the next cycle.
`define CHK_HOLD(label, clk, rst_n, stall, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        stall |=> $stable(sig)) else $error(msg);

`endif

// ----- src/r2h_pkg.sv -----
// Types, constants and lookup tables shared by the RGB565 to HSV converter.
package r2h_pkg;

    localparam int unsigned Red5Max    = 31;
    localparam int unsigned Grn6Max    = 63;
    localparam int unsigned ChanMax    = 255;
    localparam int unsigned LevelScale = 100;
    localparam int unsigned HueStep    = 60;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned NumW   = 16;
    localparam int unsigned QuoW   = 8;
    localparam int unsigned HueW   = 9;
    localparam int unsigned SatW   = 8;
    localparam int unsigned LevelW = 7;

    localparam int unsigned DivBitsPerStage = 2;
    localparam int unsigned DivStages       = QuoW / DivBitsPerStage;

    localparam logic [HueW-1:0] HueWrap  = 9'd360;
    localparam logic [HueW-1:0] HueGreen = 9'd120;
    localparam logic [HueW-1:0] HueBlue  = 9'd240;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef logic [ChanW-1:0]  widen5_tab_t [32];
    typedef logic [ChanW-1:0]  widen6_tab_t [64];
    typedef logic [LevelW-1:0] level_tab_t [256];

    typedef struct packed {
        sector_t           sector;
        logic              neg;
        logic              black;
        logic              grey;
        logic [LevelW-1:0] level;
    } side_t;

    typedef struct packed {
        logic [NumW-1:0]  sat_num;
        logic [ChanW-1:0] sat_den;
        logic [NumW-1:0]  hue_num;
        logic [ChanW-1:0] hue_den;
        side_t            side;
    } front_t;

    function automatic widen5_tab_t build_widen5();
        widen5_tab_t tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = ChanW'((i * ChanMax) / Red5Max);
        end
        return tab;
    endfunction

    function automatic widen6_tab_t build_widen6();
        widen6_tab_t tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = ChanW'((i * ChanMax) / Grn6Max);
        end
        return tab;
    endfunction

    function automatic level_tab_t build_level();
        level_tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = LevelW'((i * LevelScale) / ChanMax);
        end
        return tab;
    endfunction

    localparam widen5_tab_t Widen5Tab = build_widen5();
    localparam widen6_tab_t Widen6Tab = build_widen6();
    localparam level_tab_t  LevelTab  = build_level();

endpackage

// ----- src/r2h_front.sv -----
// Front stages: widen channels, find max/min and sector, form divider operands.
module r2h_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [15:0]     pixel,
    output logic            out_valid,
    output r2h_pkg::front_t out_data
);

    logic                      v1_reg, v2_reg, v3_reg;
    logic [r2h_pkg::ChanW-1:0] r_reg, g_reg, b_reg;
    logic [r2h_pkg::ChanW-1:0] r_next, g_next, b_next;

    logic [r2h_pkg::ChanW-1:0] mx_reg, d_reg, mag_reg;
    logic [r2h_pkg::ChanW-1:0] mx_next, mn_next, d_next, mag_next;
    r2h_pkg::sector_t          sector_reg, sector_next;
    logic                      neg_reg, neg_next;
    logic [r2h_pkg::ChanW:0]   diff;

    r2h_pkg::front_t           front_reg, front_next;

    always_comb
    begin
        r_next = r2h_pkg::Widen5Tab[pixel[15:11]];
        g_next = r2h_pkg::Widen6Tab[pixel[10:5]];
        b_next = r2h_pkg::Widen5Tab[pixel[4:0]];
    end

    always_comb
    begin
        mx_next = r_reg;
        if (g_reg > mx_next)
        begin
            mx_next = g_reg;
        end
        if (b_reg > mx_next)
        begin
            mx_next = b_reg;
        end
        mn_next = r_reg;
        if (g_reg < mn_next)
        begin
            mn_next = g_reg;
        end
        if (b_reg < mn_next)
        begin
            mn_next = b_reg;
        end
        d_next = mx_next - mn_next;

        if (r_reg >= g_reg && r_reg >= b_reg)
        begin
            sector_next = r2h_pkg::SECTOR_RED;
            diff        = {1'b0, g_reg} - {1'b0, b_reg};
        end
        else if (g_reg >= b_reg)
        begin
            sector_next = r2h_pkg::SECTOR_GREEN;
            diff        = {1'b0, b_reg} - {1'b0, r_reg};
        end
        else
        begin
            sector_next = r2h_pkg::SECTOR_BLUE;
            diff        = {1'b0, r_reg} - {1'b0, g_reg};
        end
        neg_next = diff[r2h_pkg::ChanW];
        mag_next = neg_next ? r2h_pkg::ChanW'(-diff) : diff[r2h_pkg::ChanW-1:0];
    end

    always_comb
    begin
        front_next.sat_num    = r2h_pkg::NumW'({8'd0, d_reg} * 16'(r2h_pkg::ChanMax));
        front_next.sat_den    = mx_reg;
        front_next.hue_num    = r2h_pkg::NumW'({8'd0, mag_reg} * 16'(r2h_pkg::HueStep));
        front_next.hue_den    = d_reg;
        front_next.side.sector = sector_reg;
        front_next.side.neg    = neg_reg;
        front_next.side.black  = (mx_reg == '0);
        front_next.side.grey   = (d_reg == '0);
        front_next.side.level  = r2h_pkg::LevelTab[mx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            g_reg      <= g_next;
            b_reg      <= b_next;
            mx_reg     <= mx_next;
            d_reg      <= d_next;
            mag_reg    <= mag_next;
            sector_reg <= sector_next;
            neg_reg    <= neg_next;
            front_reg  <= front_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = front_reg;

endmodule

// ----- src/r2h_div.sv -----
// Pipelined restoring divider: 16-bit numerator, 8-bit divisor, 8-bit quotient.
module r2h_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [r2h_pkg::NumW-1:0]  num,
    input  logic [r2h_pkg::ChanW-1:0] den,
    output logic [r2h_pkg::QuoW-1:0]  quo
);

    localparam int unsigned DenW = r2h_pkg::ChanW;
    localparam int unsigned LowW = r2h_pkg::NumW - DenW;
    localparam int unsigned QuoW = r2h_pkg::QuoW;
    localparam int unsigned Nst  = r2h_pkg::DivStages;

    logic [DenW-1:0] rem_in  [Nst];
    logic [LowW-1:0] low_in  [Nst];
    logic [QuoW-1:0] quo_in  [Nst];
    logic [DenW-1:0] den_in  [Nst];

    logic [DenW-1:0] rem_reg [Nst];
    logic [LowW-1:0] low_reg [Nst];
    logic [QuoW-1:0] quo_reg [Nst];
    logic [DenW-1:0] den_reg [Nst];

    logic [DenW-1:0] rem_next [Nst];
    logic [LowW-1:0] low_next [Nst];
    logic [QuoW-1:0] quo_next [Nst];

    for (genvar s = 0; s < Nst; s++)
    begin : g_stage_in
        if (s == 0)
        begin : g_head
            assign rem_in[s] = num[r2h_pkg::NumW-1:LowW];
            assign low_in[s] = num[LowW-1:0];
            assign quo_in[s] = '0;
            assign den_in[s] = den;
        end
        else
        begin : g_body
            assign rem_in[s] = rem_reg[s-1];
            assign low_in[s] = low_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
            assign den_in[s] = den_reg[s-1];
        end
    end

    always_comb
    begin
        logic [DenW:0]   trial;
        logic [DenW-1:0] rem;
        logic [LowW-1:0] low;
        logic [QuoW-1:0] q;
        for (int s = 0; s < Nst; s++)
        begin
            rem = rem_in[s];
            low = low_in[s];
            q   = quo_in[s];
            for (int k = 0; k < r2h_pkg::DivBitsPerStage; k++)
            begin
                trial = {rem, low[LowW-1]};
                low   = {low[LowW-2:0], 1'b0};
                if (trial >= {1'b0, den_in[s]})
                begin
                    rem = DenW'(trial - {1'b0, den_in[s]});
                    q   = {q[QuoW-2:0], 1'b1};
                end
                else
                begin
                    rem = trial[DenW-1:0];
                    q   = {q[QuoW-2:0], 1'b0};
                end
            end
            rem_next[s] = rem;
            low_next[s] = low;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Nst; s++)
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_in[s];
            end
        end
    end

    assign quo = quo_reg[Nst-1];

endmodule

// ----- src/r2h_back.sv -----
// Output stage: apply sector offset and sign to the hue, clear special cases.
module r2h_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  r2h_pkg::side_t              side,
    input  logic [r2h_pkg::QuoW-1:0]    q_hue,
    input  logic [r2h_pkg::QuoW-1:0]    q_sat,
    output logic                        out_valid,
    output logic [r2h_pkg::HueW-1:0]    hue,
    output logic [r2h_pkg::SatW-1:0]    saturation,
    output logic [r2h_pkg::LevelW-1:0]  level
);

    logic                         valid_reg;
    logic [r2h_pkg::HueW-1:0]     hue_reg, hue_next;
    logic [r2h_pkg::SatW-1:0]     sat_reg, sat_next;
    logic [r2h_pkg::LevelW-1:0]   level_reg;
    logic [r2h_pkg::HueW-1:0]     qh;

    always_comb
    begin
        qh = r2h_pkg::HueW'(q_hue);
        unique case (side.sector)
            r2h_pkg::SECTOR_RED:
            begin
                hue_next = (side.neg && qh != '0) ? r2h_pkg::HueWrap - qh : qh;
            end
            r2h_pkg::SECTOR_GREEN:
            begin
                hue_next = side.neg ? r2h_pkg::HueGreen - qh : r2h_pkg::HueGreen + qh;
            end
            r2h_pkg::SECTOR_BLUE:
            begin
                hue_next = side.neg ? r2h_pkg::HueBlue - qh : r2h_pkg::HueBlue + qh;
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        if (side.grey)
        begin
            hue_next = '0;
        end
        sat_next = side.black ? '0 : r2h_pkg::SatW'(q_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            level_reg <= side.level;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign level      = level_reg;

endmodule

// ----- src/rgb565_to_hsv_converter_core.sv -----
// Top level of the RGB565 to integer HSV converter pipeline.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------
//   in      | pixel_valid, pixel_ready | pixel[15:0]
//   out     | hsv_valid, hsv_ready     | hue[8:0], saturation, level
//
// One pixel enters per cycle while the stages advance; from acceptance to
// hsv_valid: 3 front stages, 4 divider stages of 2 quotient bits, 1 output.
// All stages advance together whenever the output register is empty or taken,
// so pixel_ready follows hsv_ready with no bubble and a stall loses nothing.
// Reset clears only the valid bits; the pipeline is empty after reset.
module rgb565_to_hsv_converter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [15:0]                 pixel,
    output logic                        hsv_valid,
    input  logic                        hsv_ready,
    output logic [r2h_pkg::HueW-1:0]    hue,
    output logic [r2h_pkg::SatW-1:0]    saturation,
    output logic [r2h_pkg::LevelW-1:0]  level
);

    localparam int unsigned Nst = r2h_pkg::DivStages;

    logic                        advance;
    logic                        front_valid;
    r2h_pkg::front_t             front_data;
    logic [r2h_pkg::QuoW-1:0]    q_sat, q_hue;
    logic                        div_valid_reg [Nst];
    r2h_pkg::side_t              side_reg      [Nst];

    assign advance     = !hsv_valid || hsv_ready;
    assign pixel_ready = advance;

    r2h_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (pixel_valid),
        .pixel     (pixel),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    r2h_div u_div_sat (
        .clk (clk),
        .en  (advance),
        .num (front_data.sat_num),
        .den (front_data.sat_den),
        .quo (q_sat)
    );

    r2h_div u_div_hue (
        .clk (clk),
        .en  (advance),
        .num (front_data.hue_num),
        .den (front_data.hue_den),
        .quo (q_hue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Nst; s++)
            begin
                div_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            div_valid_reg[0] <= front_valid;
            for (int s = 1; s < Nst; s++)
            begin
                div_valid_reg[s] <= div_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= front_data.side;
            for (int s = 1; s < Nst; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    r2h_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (div_valid_reg[Nst-1]),
        .side       (side_reg[Nst-1]),
        .q_hue      (q_hue),
        .q_sat      (q_sat),
        .out_valid  (hsv_valid),
        .hue        (hue),
        .saturation (saturation),
        .level      (level)
    );

endmodule

// ----- src/r2h_checker.sv -----
// Port-level checker for the converter, bound to the top level.
`include "assert_macros.svh"

module r2h_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_ready,
    input logic                        hsv_valid,
    input logic                        hsv_ready,
    input logic [r2h_pkg::HueW-1:0]    hue,
    input logic [r2h_pkg::SatW-1:0]    saturation,
    input logic [r2h_pkg::LevelW-1:0]  level
);

    logic [r2h_pkg::HueW+r2h_pkg::SatW+r2h_pkg::LevelW:0] hsv_bits;

    assign hsv_bits = {hsv_valid, hue, saturation, level};

    `CHK_CLK(a_hue_range, clk, rst_n, hsv_valid |-> hue < 9'd360, "hue out of range")
    `CHK_CLK(a_level_range, clk, rst_n, hsv_valid |-> level <= 7'd100, "level above 100")
    `CHK_CLK(a_grey_hue, clk, rst_n, (hsv_valid && saturation == '0) |-> hue == '0, "grey hue")
    `CHK_CLK(a_ready_when_empty, clk, rst_n, !hsv_valid |-> pixel_ready, "input stalled")
    `CHK_HOLD(a_out_hold, clk, rst_n, hsv_valid && !hsv_ready, hsv_bits, "stalled item changed")

endmodule

bind rgb565_to_hsv_converter_core r2h_checker u_r2h_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_ready (pixel_ready),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hue         (hue),
    .saturation  (saturation),
    .level       (level)
);
